### hw/rtl/map_bias_clamp_and_fade_macros.svh
// Assertion macros for the map bias clamp and fade block.
// Used by the top level; no other dependencies.
`ifndef MAP_BIAS_CLAMP_AND_FADE_MACROS_SVH
`define MAP_BIAS_CLAMP_AND_FADE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MBCF_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MBCF_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mbcf_pkg.sv
// Shared types and constants for the map bias clamp and fade block.
// No dependencies.
`default_nettype none

package mbcf_pkg;

   // field widths
   localparam int INNO_W  = 32;
   localparam int VEL_W   = 24;
   localparam int DT_W    = 24;
   localparam int BIAS_W  = 32;
   localparam int RATIO_W = 16;
   localparam int LIM_W   = 31;
   localparam int GAP_W   = 23;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 31;

   // serial arithmetic widths
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = 64;
   localparam int ROOT_W  = 32;
   localparam int REM_W   = 36;
   localparam int CNT_W   = 5;
   localparam int BND_W   = 28;
   localparam int BND_SH  = 36;

   // op codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_FADE   = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LATERAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FADE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FUSION   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UPD_GAP  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FADE_GAP = 3'd6;

   // register reset values
   localparam logic [RATIO_W-1:0] RST_LATERAL  = 16'd655;
   localparam logic [LIM_W-1:0]   RST_LIMIT    = 31'd81920;
   localparam logic [LIM_W-1:0]   RST_TRIGGER  = 31'd2048;
   localparam logic [RATIO_W-1:0] RST_FADE     = 16'd655;
   localparam logic               RST_FUSION   = 1'b0;
   localparam logic [GAP_W-1:0]   RST_UPD_GAP  = 23'd524288;
   localparam logic [GAP_W-1:0]   RST_FADE_GAP = 23'd1048576;

   typedef enum logic [1:0] {
      ST_APPLIED  = 2'd0,
      ST_BAD_STEP = 2'd1,
      ST_BELOW    = 2'd2,
      ST_ZERO     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK,
      S_U_SQE, S_U_SQN, S_U_SQT, S_U_BE1, S_U_BE2, S_U_BN1, S_U_BN2, S_U_APPLY,
      S_F_SQE, S_F_SQN, S_F_SPD, S_F_MX1, S_F_MX2, S_F_BSE, S_F_BSN, S_F_NRM,
      S_F_ME, S_F_DE, S_F_MN, S_F_DN, S_F_APPLY,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic              start;
      logic              is_sqrt;
      logic [PROD_W-1:0] num;
      logic [ROOT_W-1:0] den;
   } sqd_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] result;
   } sqd_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/mbcf_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mbcf_pkg.
`default_nettype none

module mbcf_mul (
   input  logic                clock,
   input  logic                reset,
   input  mbcf_pkg::mul_req_type mul_req,
   output mbcf_pkg::mul_rsp_type mul_rsp
);
   import mbcf_pkg::*;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PROD_W-1:0]  mcand_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [MUL_B_W-1:0] mplier_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift-add datapath, LSB of multiplier first
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         mcand_ff  <= PROD_W'(mul_req.a);
         mplier_ff <= mul_req.b;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MUL_B_W-1:1]};
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

`default_nettype wire

### hw/rtl/mbcf_sqd.sv
// Digit-serial square root and divider sharing one compare-subtract stage.
// One result bit per cycle. Depends on mbcf_pkg.
`default_nettype none

module mbcf_sqd (
   input  logic                clock,
   input  logic                reset,
   input  mbcf_pkg::sqd_req_type sqd_req,
   output mbcf_pkg::sqd_rsp_type sqd_rsp
);
   import mbcf_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              sqrt_ff;
   logic [PROD_W-1:0] shf_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] res_ff;
   logic [ROOT_W-1:0] den_ff;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              take;

   // bring down two bits (root) or one bit (quotient), then trial subtract
   always_comb begin
      if (sqrt_ff) begin
         rem_shift = {rem_ff[REM_W-3:0], shf_ff[PROD_W-1:PROD_W-2]};
         trial     = {2'b00, res_ff, 2'b01};
      end else begin
         rem_shift = {rem_ff[REM_W-2:0], shf_ff[PROD_W-1]};
         trial     = {{(REM_W-ROOT_W){1'b0}}, den_ff};
      end
      take = (rem_shift >= trial);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqd_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath; a quotient is known to fit ROOT_W bits, so the high half
   // of the dividend seeds the remainder
   always_ff @(posedge clock) begin
      if (sqd_req.start) begin
         sqrt_ff <= sqd_req.is_sqrt;
         den_ff  <= sqd_req.den;
         res_ff  <= '0;
         if (sqd_req.is_sqrt) begin
            shf_ff <= sqd_req.num;
            rem_ff <= '0;
         end else begin
            shf_ff <= {sqd_req.num[ROOT_W-1:0], {(PROD_W-ROOT_W){1'b0}}};
            rem_ff <= {{(REM_W-ROOT_W){1'b0}}, sqd_req.num[PROD_W-1:ROOT_W]};
         end
      end else if (busy_ff) begin
         rem_ff <= take ? (rem_shift - trial) : rem_shift;
         res_ff <= {res_ff[ROOT_W-2:0], take};
         if (sqrt_ff) begin
            shf_ff <= {shf_ff[PROD_W-3:0], 2'b00};
         end else begin
            shf_ff <= {shf_ff[PROD_W-2:0], 1'b0};
         end
      end
   end

   assign sqd_rsp.done   = done_ff;
   assign sqd_rsp.result = res_ff;

endmodule

`default_nettype wire

### hw/rtl/map_bias_clamp_and_fade.sv
// Map bias clamp and fade: top level with sequencer, bias state and registers.
// Each serial multiply, root or divide holds the sequencer state until its unit reports done. An
// applied update runs 7 multiplies, one below threshold runs 3, and a fade runs 12 operations;
// a rejected step or a fade of zero bias goes straight to the done state.
// One word in flight; the next is accepted while
// a result waits on rsp. Synchronous active-high reset clears bias and handshake state.
`default_nettype none

module map_bias_clamp_and_fade (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_innovation_east,
   input  logic [31:0] req_innovation_north,
   input  logic [23:0] req_velocity_east,
   input  logic [23:0] req_velocity_north,
   input  logic [23:0] req_time_step,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_bias_east_out,
   output logic [31:0] rsp_bias_north_out,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_data
);
   import mbcf_pkg::*;
`include "map_bias_clamp_and_fade_macros.svh"

   // configuration
   logic [RATIO_W-1:0] lateral_ff;
   logic [LIM_W-1:0]   limit_ff;
   logic [LIM_W-1:0]   trigger_ff;
   logic [RATIO_W-1:0] fade_ratio_ff;
   logic               fusion_ff;
   logic [GAP_W-1:0]   upd_gap_ff;
   logic [GAP_W-1:0]   fade_gap_ff;

   // control
   state_type state_ff, state_in;
   logic      issued_ff, issued_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;
   status_type status_ff;

   // captured word
   logic              op_ff;
   logic [INNO_W-1:0] ie_ff, in_ff;
   logic [VEL_W-1:0]  ve_ff, vn_ff;
   logic [DT_W-1:0]   dt_ff;

   // working registers
   logic [BIAS_W-1:0] bias_e_ff, bias_n_ff;
   logic [PROD_W-1:0] sum_ff, prod_ff;
   logic [BND_W-1:0]  bnd_e_ff, bnd_n_ff, maxf_ff;
   logic [ROOT_W-1:0] speed_ff, norm_ff, de_ff, dn_ff;
   logic [BIAS_W-1:0] rsp_e_ff, rsp_n_ff;
   logic [1:0]        rsp_st_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   sqd_req_type sqd_req;
   sqd_rsp_type sqd_rsp;

   // derived operands
   logic [INNO_W-1:0] ae, an;
   logic [VEL_W-1:0]  ave, avn;
   logic [BIAS_W-1:0] abe, abn;
   logic [LIM_W-1:0]  thr;
   logic [ROOT_W-1:0] fade_len;
   logic              step_bad, bias_zero, below;
   logic [INNO_W-1:0] step_e, step_n;
   logic [BIAS_W-1:0] upd_e, upd_n, fad_e, fad_n;

   function automatic logic [BIAS_W-1:0] sat_add(input logic [BIAS_W-1:0] b,
                                                 input logic neg,
                                                 input logic [INNO_W-1:0] smag,
                                                 input logic [LIM_W-1:0] lim);
      logic signed [33:0] s;
      logic signed [33:0] st;
      logic signed [33:0] l;
      logic signed [33:0] nl;
      st = $signed({2'b00, smag});
      s  = $signed({{2{b[BIAS_W-1]}}, b}) + (neg ? -st : st);
      l  = $signed({3'b000, lim});
      nl = -l;
      if (s > l) begin
         return l[BIAS_W-1:0];
      end else if (s < nl) begin
         return nl[BIAS_W-1:0];
      end
      return s[BIAS_W-1:0];
   endfunction

   function automatic logic [BIAS_W-1:0] shrink(input logic [BIAS_W-1:0] b,
                                                input logic [ROOT_W-1:0] d);
      logic [BIAS_W-1:0] m;
      m = b[BIAS_W-1] ? -b : b;
      m = m - d;
      return b[BIAS_W-1] ? -m : m;
   endfunction

   // magnitudes and checks
   always_comb begin
      ae  = ie_ff[INNO_W-1] ? -ie_ff : ie_ff;
      an  = in_ff[INNO_W-1] ? -in_ff : in_ff;
      ave = ve_ff[VEL_W-1] ? -ve_ff : ve_ff;
      avn = vn_ff[VEL_W-1] ? -vn_ff : vn_ff;
      abe = bias_e_ff[BIAS_W-1] ? -bias_e_ff : bias_e_ff;
      abn = bias_n_ff[BIAS_W-1] ? -bias_n_ff : bias_n_ff;
      thr = fusion_ff ? {1'b0, trigger_ff[LIM_W-1:1]} : trigger_ff;
      step_bad = dt_ff[DT_W-1] ||
                 (dt_ff[GAP_W-1:0] > ((op_ff == OP_FADE) ? fade_gap_ff : upd_gap_ff));
      bias_zero = (bias_e_ff == '0) && (bias_n_ff == '0);
      below = (sum_ff < mul_rsp.product);
      fade_len = ({4'b0000, maxf_ff} < norm_ff) ? {4'b0000, maxf_ff} : norm_ff;
      step_e = (ae > {4'b0000, bnd_e_ff}) ? {4'b0000, bnd_e_ff} : ae;
      step_n = (an > {4'b0000, bnd_n_ff}) ? {4'b0000, bnd_n_ff} : an;
      upd_e = sat_add(bias_e_ff, ie_ff[INNO_W-1], step_e, limit_ff);
      upd_n = sat_add(bias_n_ff, in_ff[INNO_W-1], step_n, limit_ff);
      fad_e = shrink(bias_e_ff, de_ff);
      fad_n = shrink(bias_n_ff, dn_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (step_bad) begin
               state_in = S_DONE;
            end else if (op_ff == OP_FADE) begin
               state_in = bias_zero ? S_DONE : S_F_SQE;
            end else begin
               state_in = S_U_SQE;
            end
         end
         S_U_SQE:   if (mul_rsp.done) state_in = S_U_SQN;
         S_U_SQN:   if (mul_rsp.done) state_in = S_U_SQT;
         S_U_SQT:   if (mul_rsp.done) state_in = below ? S_DONE : S_U_BE1;
         S_U_BE1:   if (mul_rsp.done) state_in = S_U_BE2;
         S_U_BE2:   if (mul_rsp.done) state_in = S_U_BN1;
         S_U_BN1:   if (mul_rsp.done) state_in = S_U_BN2;
         S_U_BN2:   if (mul_rsp.done) state_in = S_U_APPLY;
         S_U_APPLY: state_in = S_DONE;
         S_F_SQE:   if (mul_rsp.done) state_in = S_F_SQN;
         S_F_SQN:   if (mul_rsp.done) state_in = S_F_SPD;
         S_F_SPD:   if (sqd_rsp.done) state_in = S_F_MX1;
         S_F_MX1:   if (mul_rsp.done) state_in = S_F_MX2;
         S_F_MX2:   if (mul_rsp.done) state_in = S_F_BSE;
         S_F_BSE:   if (mul_rsp.done) state_in = S_F_BSN;
         S_F_BSN:   if (mul_rsp.done) state_in = S_F_NRM;
         S_F_NRM:   if (sqd_rsp.done) state_in = S_F_ME;
         S_F_ME:    if (mul_rsp.done) state_in = S_F_DE;
         S_F_DE:    if (sqd_rsp.done) state_in = S_F_MN;
         S_F_MN:    if (mul_rsp.done) state_in = S_F_DN;
         S_F_DN:    if (sqd_rsp.done) state_in = S_F_APPLY;
         S_F_APPLY: state_in = S_DONE;
         S_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs: unit requests, handshake
   always_comb begin
      mul_req = '0;
      sqd_req = '0;
      case (state_ff)
         S_U_SQE: begin mul_req.a = MUL_A_W'(ae);  mul_req.b = ae; end
         S_U_SQN: begin mul_req.a = MUL_A_W'(an);  mul_req.b = an; end
         S_U_SQT: begin mul_req.a = MUL_A_W'(thr); mul_req.b = MUL_B_W'(thr); end
         S_U_BE1, S_F_MX1: begin
            mul_req.a = (state_ff == S_F_MX1) ? MUL_A_W'(speed_ff) : MUL_A_W'(avn);
            mul_req.b = MUL_B_W'(dt_ff[GAP_W-1:0]);
         end
         S_U_BN1: begin
            mul_req.a = MUL_A_W'(ave);
            mul_req.b = MUL_B_W'(dt_ff[GAP_W-1:0]);
         end
         S_U_BE2, S_U_BN2: begin
            mul_req.a = prod_ff[MUL_A_W-1:0];
            mul_req.b = MUL_B_W'(lateral_ff);
         end
         S_F_MX2: begin
            mul_req.a = prod_ff[MUL_A_W-1:0];
            mul_req.b = MUL_B_W'(fade_ratio_ff);
         end
         S_F_SQE: begin mul_req.a = MUL_A_W'(ave); mul_req.b = MUL_B_W'(ave); end
         S_F_SQN: begin mul_req.a = MUL_A_W'(avn); mul_req.b = MUL_B_W'(avn); end
         S_F_BSE: begin mul_req.a = MUL_A_W'(abe); mul_req.b = abe; end
         S_F_BSN: begin mul_req.a = MUL_A_W'(abn); mul_req.b = abn; end
         S_F_ME:  begin mul_req.a = MUL_A_W'(abe); mul_req.b = fade_len; end
         S_F_MN:  begin mul_req.a = MUL_A_W'(abn); mul_req.b = fade_len; end
         S_F_SPD, S_F_NRM: begin
            sqd_req.is_sqrt = 1'b1;
            sqd_req.num     = sum_ff;
         end
         S_F_DE, S_F_DN: begin
            sqd_req.num = prod_ff;
            sqd_req.den = norm_ff;
         end
         default: begin
            mul_req = '0;
            sqd_req = '0;
         end
      endcase
      case (state_ff)
         S_F_SPD, S_F_NRM, S_F_DE, S_F_DN: sqd_req.start = !issued_ff;
         S_IDLE, S_CHECK, S_U_APPLY, S_F_APPLY, S_DONE: begin
            mul_req.start = 1'b0;
            sqd_req.start = 1'b0;
         end
         default: mul_req.start = !issued_ff;
      endcase
      issued_in = issued_ff;
      if (mul_req.start || sqd_req.start) begin
         issued_in = 1'b1;
      end else if (mul_rsp.done || sqd_rsp.done) begin
         issued_in = 1'b0;
      end
      req_stall    = (state_ff != S_IDLE);
      rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lateral_ff    <= RST_LATERAL;
         limit_ff      <= RST_LIMIT;
         trigger_ff    <= RST_TRIGGER;
         fade_ratio_ff <= RST_FADE;
         fusion_ff     <= RST_FUSION;
         upd_gap_ff    <= RST_UPD_GAP;
         fade_gap_ff   <= RST_FADE_GAP;
      end else if (csr_write) begin
         case (csr_index)
            REG_LATERAL:  lateral_ff    <= csr_data[RATIO_W-1:0];
            REG_LIMIT:    limit_ff      <= csr_data[LIM_W-1:0];
            REG_TRIGGER:  trigger_ff    <= csr_data[LIM_W-1:0];
            REG_FADE:     fade_ratio_ff <= csr_data[RATIO_W-1:0];
            REG_FUSION:   fusion_ff     <= csr_data[0];
            REG_UPD_GAP:  upd_gap_ff    <= csr_data[GAP_W-1:0];
            REG_FADE_GAP: fade_gap_ff   <= csr_data[GAP_W-1:0];
            default:      lateral_ff    <= lateral_ff;
         endcase
      end
   end

   // bias state
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_e_ff <= '0;
         bias_n_ff <= '0;
      end else if (state_ff == S_U_APPLY) begin
         bias_e_ff <= upd_e;
         bias_n_ff <= upd_n;
      end else if (state_ff == S_F_APPLY) begin
         bias_e_ff <= fad_e;
         bias_n_ff <= fad_n;
      end
   end

   // word capture, status and intermediate results
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_op;
         ie_ff <= req_innovation_east;
         in_ff <= req_innovation_north;
         ve_ff <= req_velocity_east;
         vn_ff <= req_velocity_north;
         dt_ff <= req_time_step;
      end
      if (state_ff == S_CHECK) begin
         if (step_bad) begin
            status_ff <= ST_BAD_STEP;
         end else if (op_ff == OP_FADE && bias_zero) begin
            status_ff <= ST_ZERO;
         end else begin
            status_ff <= ST_APPLIED;
         end
      end
      if (mul_rsp.done) begin
         prod_ff <= mul_rsp.product;
         case (state_ff)
            S_U_SQE, S_F_SQE, S_F_BSE: sum_ff <= mul_rsp.product;
            S_U_SQN, S_F_SQN, S_F_BSN: sum_ff <= sum_ff + mul_rsp.product;
            S_U_SQT: if (below) status_ff <= ST_BELOW;
            S_U_BE2: bnd_e_ff <= mul_rsp.product[PROD_W-1:BND_SH];
            S_U_BN2: bnd_n_ff <= mul_rsp.product[PROD_W-1:BND_SH];
            S_F_MX2: maxf_ff  <= mul_rsp.product[PROD_W-1:BND_SH];
            default: sum_ff   <= sum_ff;
         endcase
      end
      if (sqd_rsp.done) begin
         case (state_ff)
            S_F_SPD: speed_ff <= sqd_rsp.result;
            S_F_NRM: norm_ff  <= sqd_rsp.result;
            S_F_DE:  de_ff    <= sqd_rsp.result;
            S_F_DN:  dn_ff    <= sqd_rsp.result;
            default: de_ff    <= de_ff;
         endcase
      end
      if (rsp_load) begin
         rsp_e_ff  <= bias_e_ff;
         rsp_n_ff  <= bias_n_ff;
         rsp_st_ff <= status_ff;
      end
   end

   mbcf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   mbcf_sqd u_sqd (
      .clock   (clock),
      .reset   (reset),
      .sqd_req (sqd_req),
      .sqd_rsp (sqd_rsp)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bias_east_out  = rsp_e_ff;
   assign rsp_bias_north_out = rsp_n_ff;
   assign rsp_status         = rsp_st_ff;

   // checks
   `MBCF_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
      req_stall, "accepted word did not start work")
   `MBCF_ASSERT_IMP(a_zero_status, clock, reset, rsp_valid && (rsp_status == ST_ZERO),
      (rsp_bias_east_out == '0) && (rsp_bias_north_out == '0), "zero status with nonzero bias")
   `MBCF_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_DONE, "result raised outside done state")
   `MBCF_ASSERT_IMP(a_one_unit, clock, reset, 1'b1,
      !(mul_req.start && sqd_req.start), "both arithmetic units started")

endmodule

`default_nettype wire
